// ===== rtl/rag_deadlock_cycle_detect_defines.svh =====
// Assertion macros for the deadlock detector.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef RAG_DEADLOCK_CYCLE_DETECT_DEFINES_SVH
`define RAG_DEADLOCK_CYCLE_DETECT_DEFINES_SVH

// cond implies prop in the same cycle
`define RDCD_ASSERT_IMP(name, cond, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// cond never holds
`define RDCD_ASSERT_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// ===== rtl/rdcd_pkg.sv =====
// Shared types and constants of the deadlock detector.
// No dependencies.
package rdcd_pkg;

  // widest vertex number over the legal parameter range (up to 64 vertices)
  localparam int VERT_W     = 6;
  localparam int KIND_W     = 2;
  localparam int PID_W      = 5;
  localparam int LOCKID_W   = 4;
  localparam int VID_W      = 5;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_REQUEST = 2'd0,
    KIND_ALLOC   = 2'd1,
    KIND_DEALLOC = 2'd2,
    KIND_DETECT  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [VERT_W-1:0] pv;  // process vertex
    logic [VERT_W-1:0] lv;  // lock vertex
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROOT,
    BK_SCAN,
    BK_POP_WAIT,
    BK_RPT_TOP,
    BK_RPT_RD,
    BK_RPT_EMIT,
    BK_NOT_FOUND
  } bk_state_e;

endpackage

// ===== rtl/rdcd_front.sv =====
// Front end: range-checks request items and turns them into vertex commands.
// Depends on rdcd_pkg.
module rdcd_front
  import rdcd_pkg::*;
#(
  parameter int NUM_LOCKS    = 10,
  parameter int NUM_PROCS    = 20,
  parameter int NUM_VERTICES = 30
) (
  input  logic                push_i,
  input  logic                full_i,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [PID_W-1:0]    pid_i,
  input  logic [LOCKID_W-1:0] lockid_i,
  output logic                enq_o,
  output cmd_t                cmd_o
);

  logic [VERT_W:0] pvert;
  logic            in_range;
  kind_e           kind;

  assign kind  = kind_e'(kind_i);
  assign pvert = (VERT_W+1)'(NUM_LOCKS) + (VERT_W+1)'(pid_i);

  assign in_range = (pid_i < NUM_PROCS) && (lockid_i < NUM_LOCKS) &&
                    (pvert < NUM_VERTICES) && (lockid_i < NUM_VERTICES);

  // out-of-range edge updates are dropped here and never queued
  assign enq_o = push_i && !full_i && ((kind == KIND_DETECT) || in_range);

  assign cmd_o.kind = kind;
  assign cmd_o.pv   = pvert[VERT_W-1:0];
  assign cmd_o.lv   = VERT_W'(lockid_i);

endmodule

// ===== rtl/rdcd_cmdq.sv =====
// Small command queue between front end and search engine.
// Depends on rdcd_pkg.
module rdcd_cmdq
  import rdcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic enq_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic deq_i
);

  cmd_t               slot_q [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr_q, wptr_d;
  logic [CMDQ_AW-1:0] rptr_q, rptr_d;
  logic [CMDQ_AW:0]   cnt_q, cnt_d;
  logic               do_deq;

  assign full_o  = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rptr_q];
  assign do_deq  = deq_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (enq_i) begin
      wptr_d = wptr_q + CMDQ_AW'(1);
    end
    if (do_deq) begin
      rptr_d = rptr_q + CMDQ_AW'(1);
    end
    case ({enq_i, do_deq})
      2'b10:   cnt_d = cnt_q + (CMDQ_AW+1)'(1);
      2'b01:   cnt_d = cnt_q - (CMDQ_AW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq_i) begin
      slot_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/rdcd_back.sv =====
// Back end: adjacency matrix, depth-first search engine, path report and result register.
// Depends on rdcd_pkg.
module rdcd_back
  import rdcd_pkg::*;
#(
  parameter int NUM_LOCKS    = 10,
  parameter int NUM_VERTICES = 30
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cmd_valid_i,
  input  cmd_t             cmd_i,
  output logic             cmd_deq_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic             found_o,
  output logic             vertex_is_lock_o,
  output logic [VID_W-1:0] vertex_id_o,
  output logic             last_o
);

  localparam int VW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
  localparam int IW = VW + 1;                       // scan index, reaches NUM_VERTICES
  localparam int DW = $clog2(NUM_VERTICES + 1);     // walk depth
  localparam int EW = VW + IW;                      // stack entry: vertex, next neighbor

  bk_state_e st_q, st_d;

  logic [NUM_VERTICES-1:0] adj_q [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] adj_d [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] vis_q, vis_d, onp_q, onp_d;
  logic [IW-1:0]           root_q, root_d;
  logic [DW-1:0]           depth_q, depth_d;
  logic [VW-1:0]           curv_q, curv_d;
  logic [IW-1:0]           curi_q, curi_d;
  logic [VW-1:0]           rpt_q, rpt_d;
  logic                    oval_q, oval_d;
  logic                    ofound_q, olock_q, olast_q;
  logic [VID_W-1:0]        oid_q;

  // walk stack memory
  logic [EW-1:0] stk_mem [NUM_VERTICES];
  logic [EW-1:0] stk_rd_q;
  logic          stk_we, stk_re;
  logic [VW-1:0] stk_wa, stk_ra;
  logic [EW-1:0] stk_wd;

  logic          pop_out, out_free;
  logic          scan_end, hit, root_end;
  logic [VW-1:0] ci, ri, cpv, clv;
  logic          emit_en, emit_found, emit_last;
  logic [VW-1:0] emit_v;
  logic          emit_lock;
  logic [VERT_W-1:0] emit_ext;
  logic [VERT_W-1:0] emit_id;

  assign pop_out  = pop_i && oval_q;
  assign out_free = !oval_q || pop_out;
  assign ci       = curi_q[VW-1:0];
  assign ri       = root_q[VW-1:0];
  assign cpv      = cmd_i.pv[VW-1:0];
  assign clv      = cmd_i.lv[VW-1:0];
  assign scan_end = (curi_q == IW'(NUM_VERTICES));
  assign root_end = (root_q == IW'(NUM_VERTICES));
  assign hit      = !scan_end && adj_q[curv_q][ci];

  // next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i && (cmd_i.kind == KIND_DETECT)) begin
          st_d = BK_ROOT;
        end
      end
      BK_ROOT: begin
        if (root_end) begin
          st_d = BK_NOT_FOUND;
        end else if (!vis_q[ri]) begin
          st_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          st_d = (depth_q == DW'(1)) ? BK_ROOT : BK_POP_WAIT;
        end else if (hit && vis_q[ci] && onp_q[ci]) begin
          st_d = BK_RPT_TOP;
        end
      end
      BK_POP_WAIT: st_d = BK_SCAN;
      BK_RPT_TOP: begin
        if (out_free) begin
          st_d = (depth_q == DW'(1)) ? BK_IDLE : BK_RPT_RD;
        end
      end
      BK_RPT_RD: st_d = BK_RPT_EMIT;
      BK_RPT_EMIT: begin
        if (out_free) begin
          st_d = (rpt_q == '0) ? BK_IDLE : BK_RPT_RD;
        end
      end
      BK_NOT_FOUND: begin
        if (out_free) begin
          st_d = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  // datapath and outputs per state
  always_comb begin
    adj_d      = adj_q;
    vis_d      = vis_q;
    onp_d      = onp_q;
    root_d     = root_q;
    depth_d    = depth_q;
    curv_d     = curv_q;
    curi_d     = curi_q;
    rpt_d      = rpt_q;
    oval_d     = oval_q && !pop_out;
    cmd_deq_o  = 1'b0;
    stk_we     = 1'b0;
    stk_wa     = '0;
    stk_wd     = '0;
    stk_re     = 1'b0;
    stk_ra     = '0;
    emit_en    = 1'b0;
    emit_found = 1'b0;
    emit_last  = 1'b0;
    emit_v     = '0;
    case (st_q)
      BK_IDLE: begin
        if (cmd_valid_i) begin
          cmd_deq_o = 1'b1;
          case (cmd_i.kind)
            KIND_REQUEST: adj_d[cpv][clv] = 1'b1;
            KIND_ALLOC: begin
              adj_d[clv][cpv] = 1'b1;
              adj_d[cpv][clv] = 1'b0;
            end
            KIND_DEALLOC: begin
              adj_d[cpv][clv] = 1'b0;
              adj_d[clv][cpv] = 1'b0;
            end
            KIND_DETECT: begin
              vis_d   = '0;
              onp_d   = '0;
              root_d  = '0;
              depth_d = '0;
            end
            default: ;
          endcase
        end
      end
      BK_ROOT: begin
        if (!root_end) begin
          if (!vis_q[ri]) begin
            vis_d[ri] = 1'b1;
            onp_d[ri] = 1'b1;
            curv_d    = ri;
            curi_d    = '0;
            depth_d   = DW'(1);
          end else begin
            root_d = root_q + IW'(1);
          end
        end
      end
      BK_SCAN: begin
        if (scan_end) begin
          onp_d[curv_q] = 1'b0;
          depth_d       = depth_q - DW'(1);
          if (depth_q == DW'(1)) begin
            root_d = root_q + IW'(1);
          end else begin
            stk_re = 1'b1;
            stk_ra = VW'(depth_q - DW'(2));
          end
        end else if (!hit) begin
          curi_d = curi_q + IW'(1);
        end else if (!vis_q[ci]) begin
          if (depth_q < NUM_VERTICES) begin
            stk_we    = 1'b1;
            stk_wa    = VW'(depth_q - DW'(1));
            stk_wd    = {curv_q, curi_q + IW'(1)};
            vis_d[ci] = 1'b1;
            onp_d[ci] = 1'b1;
            curv_d    = ci;
            curi_d    = '0;
            depth_d   = depth_q + DW'(1);
          end else begin
            curi_d = curi_q + IW'(1);
          end
        end else if (!onp_q[ci]) begin
          curi_d = curi_q + IW'(1);
        end
      end
      BK_POP_WAIT: begin
        curv_d = stk_rd_q[EW-1:IW];
        curi_d = stk_rd_q[IW-1:0];
      end
      BK_RPT_TOP: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_found = 1'b1;
          emit_v     = curv_q;
          emit_last  = (depth_q == DW'(1));
          rpt_d      = VW'(depth_q - DW'(2));
        end
      end
      BK_RPT_RD: begin
        stk_re = 1'b1;
        stk_ra = rpt_q;
      end
      BK_RPT_EMIT: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_found = 1'b1;
          emit_v     = stk_rd_q[EW-1:IW];
          emit_last  = (rpt_q == '0);
          rpt_d      = rpt_q - VW'(1);
        end
      end
      BK_NOT_FOUND: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_last = 1'b1;
        end
      end
      default: ;
    endcase
    if (emit_en) begin
      oval_d = 1'b1;
    end
  end

  // vertex number to lock or process number
  assign emit_ext  = VERT_W'(emit_v);
  assign emit_lock = emit_found && (emit_ext < NUM_LOCKS);
  assign emit_id   = !emit_found ? '0 :
                     (emit_ext < NUM_LOCKS) ? emit_ext : (emit_ext - VERT_W'(NUM_LOCKS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_IDLE;
      vis_q   <= '0;
      onp_q   <= '0;
      root_q  <= '0;
      depth_q <= '0;
      rpt_q   <= '0;
      oval_q  <= 1'b0;
      for (int r = 0; r < NUM_VERTICES; r++) begin
        adj_q[r] <= '0;
      end
    end else begin
      st_q    <= st_d;
      vis_q   <= vis_d;
      onp_q   <= onp_d;
      root_q  <= root_d;
      depth_q <= depth_d;
      rpt_q   <= rpt_d;
      oval_q  <= oval_d;
      adj_q   <= adj_d;
    end
  end

  always_ff @(posedge clk_i) begin
    curv_q <= curv_d;
    curi_q <= curi_d;
    if (emit_en) begin
      ofound_q <= emit_found;
      olock_q  <= emit_lock;
      oid_q    <= emit_id[VID_W-1:0];
      olast_q  <= emit_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= stk_wd;
    end
    if (stk_re) begin
      stk_rd_q <= stk_mem[stk_ra];
    end
  end

  assign empty_o          = !oval_q;
  assign found_o          = ofound_q;
  assign vertex_is_lock_o = olock_q;
  assign vertex_id_o      = oid_q;
  assign last_o           = olast_q;

endmodule

// ===== rtl/rag_deadlock_cycle_detect.sv =====
// Top level of the resource allocation graph deadlock detector.
// Depends on rdcd_pkg, rdcd_front, rdcd_cmdq, rdcd_back and the defines header.
//
//   channel   handshake          payload
//   -------   ----------------   ------------------------------------------
//   request   push / full        kind_i, pid_i, lockid_i
//   result    empty / pop        found_o, vertex_is_lock_o, vertex_id_o, last_o
//
// Edge updates are applied while the search engine is idle and give no result.
// A detect scans neighbor bits one at a time, moves on to each new root and
//   backtracks through a stack memory read; on a hit it reports the deepest
//   path vertex first, then each path vertex above it, each read from the stack.
// Reset is asynchronous and clears the adjacency matrix at once; no clearing pass.
// A two-entry command queue keeps taking requests while a search runs or a
// result waits; the engine stalls only when its result register is still full.
`include "rag_deadlock_cycle_detect_defines.svh"

module rag_deadlock_cycle_detect
  import rdcd_pkg::*;
#(
  parameter int NUM_LOCKS    = 10,
  parameter int NUM_PROCS    = 20,
  parameter int NUM_VERTICES = 30
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // request side
  input  logic                push,
  output logic                full,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [PID_W-1:0]    pid_i,
  input  logic [LOCKID_W-1:0] lockid_i,
  // result side
  output logic                empty,
  input  logic                pop,
  output logic                found_o,
  output logic                vertex_is_lock_o,
  output logic [VID_W-1:0]    vertex_id_o,
  output logic                last_o
);

  logic enq;
  cmd_t enq_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_deq;

  // decode and range check; out-of-range edge updates are dropped here
  rdcd_front #(
    .NUM_LOCKS    (NUM_LOCKS),
    .NUM_PROCS    (NUM_PROCS),
    .NUM_VERTICES (NUM_VERTICES)
  ) u_front (
    .push_i   (push),
    .full_i   (full),
    .kind_i   (kind_i),
    .pid_i    (pid_i),
    .lockid_i (lockid_i),
    .enq_o    (enq),
    .cmd_o    (enq_cmd)
  );

  // decouples the request side from the search engine
  rdcd_cmdq u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .enq_i   (enq),
    .cmd_i   (enq_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .deq_i   (q_deq)
  );

  // graph store, depth-first search and result register
  rdcd_back #(
    .NUM_LOCKS    (NUM_LOCKS),
    .NUM_VERTICES (NUM_VERTICES)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_valid_i      (q_valid),
    .cmd_i            (q_cmd),
    .cmd_deq_o        (q_deq),
    .pop_i            (pop),
    .empty_o          (empty),
    .found_o          (found_o),
    .vertex_is_lock_o (vertex_is_lock_o),
    .vertex_id_o      (vertex_id_o),
    .last_o           (last_o)
  );

  // only the final result of a run may report not-found
  `RDCD_ASSERT_IMP(a_mid_path_found, !empty && !last_o, found_o, "path result without found")
  // a not-found result carries zero vertex fields
  `RDCD_ASSERT_IMP(a_not_found_zero, !empty && !found_o,
                   last_o && !vertex_is_lock_o && (vertex_id_o == '0), "bad not-found result")
  // a reported lock number is a real lock
  `RDCD_ASSERT_NEVER(a_lock_range, !empty && vertex_is_lock_o && (vertex_id_o >= NUM_LOCKS),
                     "lock number out of range")

endmodule

// ===== tb/sv/rag_deadlock_cycle_detect_tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for rag_deadlock_cycle_detect: edits the lock/process graph, runs
// cycle searches and checks every reported path vertex against its own graph walk.
// Depends on rdcd_pkg and the RTL of rag_deadlock_cycle_detect.
module rag_deadlock_cycle_detect_tb;
  import rdcd_pkg::*;

  localparam int NL           = 10;        // locks, vertices 0 .. NL-1
  localparam int NP           = 20;        // processes, vertices NL .. NL+NP-1
  localparam int NV           = NL + NP;
  localparam int ITEM_TARGET  = 410;       // requests over the whole run
  localparam int HOLD_CYCLES  = 3000;      // result side held off in the pressure test
  localparam int DRAIN_CYCLES = 1200;      // a little over one full search
  // room for every search and its stalled pops, taken several times over
  localparam int CYCLE_LIMIT  = 2500000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic             found;
    logic             is_lock;
    logic [VID_W-1:0] id;
    logic             last;
  } path_vertex_t;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                push     = 1'b0;
  logic                full;
  logic [KIND_W-1:0]   kind_i   = KIND_REQUEST;
  logic [PID_W-1:0]    pid_i    = '0;
  logic [LOCKID_W-1:0] lockid_i = '0;
  logic                empty;
  logic                pop      = 1'b0;
  logic                found_o;
  logic                vertex_is_lock_o;
  logic [VID_W-1:0]    vertex_id_o;
  logic                last_o;

  rag_deadlock_cycle_detect dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .kind_i           (kind_i),
    .pid_i            (pid_i),
    .lockid_i         (lockid_i),
    .empty            (empty),
    .pop              (pop),
    .found_o          (found_o),
    .vertex_is_lock_o (vertex_is_lock_o),
    .vertex_id_o      (vertex_id_o),
    .last_o           (last_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Graph model and expected path vertices
  // ---------------------------------------------------------------------------
  // rag_adj[v][u] set means edge v -> u. Process p sits at vertex NL + p.
  logic [NV-1:0] rag_adj [NV];
  path_vertex_t  expected_path_q [$];

  int items_applied     = 0;   // edge edits in range plus searches
  int items_ignored     = 0;   // out of range edits, dropped by the block
  int searches_found    = 0;
  int searches_clean    = 0;
  int longest_path      = 0;
  int results_checked   = 0;
  int mismatches        = 0;
  int full_stall_cycles = 0;
  int cycle_count       = 0;

  // Depth-first walk from every vertex in order, neighbors in order; the first
  // edge back onto the current path ends the search and the path is reported
  // deepest vertex first.
  function automatic void predict_cycle_search();
    logic [NV-1:0] seen;
    logic [NV-1:0] on_path;
    int            stk_vert [NV];
    int            stk_next [NV];
    int            depth;
    int            top;
    int            v;
    int            i;
    bit            hit;
    path_vertex_t  pv;
    seen    = '0;
    on_path = '0;
    hit     = 1'b0;
    for (int root = 0; root < NV && !hit; root++) begin
      if (!seen[root]) begin
        seen[root]    = 1'b1;
        on_path[root] = 1'b1;
        stk_vert[0]   = root;
        stk_next[0]   = 0;
        depth         = 1;
        while (depth > 0 && !hit) begin
          top = depth - 1;
          v   = stk_vert[top];
          i   = stk_next[top];
          while (i < NV && !rag_adj[v][i]) i++;
          if (i >= NV) begin
            // dead end: leave the path
            on_path[v] = 1'b0;
            depth--;
          end else begin
            stk_next[top] = i + 1;
            if (!seen[i]) begin
              if (depth < NV) begin
                seen[i]         = 1'b1;
                on_path[i]      = 1'b1;
                stk_vert[depth] = i;
                stk_next[depth] = 0;
                depth++;
              end
            end else if (on_path[i]) begin
              hit = 1'b1;
              for (int d = depth - 1; d >= 0; d--) begin
                pv.found   = 1'b1;
                pv.is_lock = (stk_vert[d] < NL);
                pv.id      = VID_W'((stk_vert[d] < NL) ? stk_vert[d] : stk_vert[d] - NL);
                pv.last    = (d == 0);
                expected_path_q.push_back(pv);
              end
              if (depth > longest_path) longest_path = depth;
            end
          end
        end
      end
    end
    if (hit) begin
      searches_found++;
    end else begin
      pv = '{found: 1'b0, is_lock: 1'b0, id: '0, last: 1'b1};
      expected_path_q.push_back(pv);
      searches_clean++;
    end
  endfunction

  // Applies one accepted request to the graph model.
  function automatic void predict_request(kind_e kind, int pid, int lockid);
    int pv;
    if (kind == KIND_DETECT) begin
      items_applied++;
      predict_cycle_search();
      return;
    end
    if (pid >= NP || lockid >= NL) begin
      items_ignored++;
      return;
    end
    items_applied++;
    pv = NL + pid;
    case (kind)
      KIND_REQUEST: begin
        rag_adj[pv][lockid] = 1'b1;
      end
      KIND_ALLOC: begin
        rag_adj[lockid][pv] = 1'b1;
        rag_adj[pv][lockid] = 1'b0;
      end
      default: begin
        rag_adj[lockid][pv] = 1'b0;
        rag_adj[pv][lockid] = 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  bit gaps_on    = 1'b1;

  // Offers one request and returns at the edge that accepts it. push stays high
  // so that requests in a burst follow back to back.
  task automatic send_request(input kind_e kind, input int pid, input int lockid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap        = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push     <= 1'b1;
    kind_i   <= kind;
    pid_i    <= pid[PID_W-1:0];
    lockid_i <= lockid[LOCKID_W-1:0];
    do @(posedge clk_i); while (full);
    predict_request(kind, pid, lockid);
  endtask

  // Removes every edge left in the graph, one deallocate per process/lock pair with an edge.
  task automatic clear_graph();
    for (int p = 0; p < NP; p++) begin
      for (int l = 0; l < NL; l++) begin
        if (rag_adj[NL+p][l] || rag_adj[l][NL+p]) send_request(KIND_DEALLOC, p, l);
      end
    end
  endtask

  int proc_pick [NP];
  int lock_pick [NL];

  task automatic shuffle_picks();
    int j;
    int t;
    for (int i = 0; i < NP; i++) proc_pick[i] = i;
    for (int i = 0; i < NL; i++) lock_pick[i] = i;
    for (int i = NP - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = proc_pick[i]; proc_pick[i] = proc_pick[j]; proc_pick[j] = t;
    end
    for (int i = NL - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = lock_pick[i]; lock_pick[i] = lock_pick[j]; lock_pick[j] = t;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop follows a rotating 16-bit pattern; a hold-off request from
  // the test process makes it stay low until a countdown from HOLD_CYCLES, kept here, ends.
  // ---------------------------------------------------------------------------
  logic [15:0] stall_pattern   = 16'hFFFF;
  logic [3:0]  stall_phase     = '0;
  int          hold_epoch      = 0;   // bumped by the test to start a hold-off
  int          hold_epoch_seen = 0;
  int          hold_left       = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_epoch != hold_epoch_seen) begin
      hold_epoch_seen <= hold_epoch;
      hold_left       <= HOLD_CYCLES;
      pop             <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop         <= stall_pattern[stall_phase];
      stall_phase <= stall_phase + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : result_check
    path_vertex_t want;
    if (rst_ni) begin
      if (push && full) full_stall_cycles++;
      if (pop && !empty) begin
        if (expected_path_q.size() == 0) begin
          report_mismatch("result with nothing pending", vertex_id_o, 0);
        end else begin
          want = expected_path_q.pop_front();
          results_checked++;
          if (found_o !== want.found) report_mismatch("found", found_o, want.found);
          if (vertex_is_lock_o !== want.is_lock)
            report_mismatch("vertex_is_lock", vertex_is_lock_o, want.is_lock);
          if (vertex_id_o !== want.id) report_mismatch("vertex_id", vertex_id_o, want.id);
          if (last_o !== want.last) report_mismatch("last", last_o, want.last);
        end
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               expected_path_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every kind, dropped edits, ignored fields on a search,
  // allocation replacing a request, deallocation breaking a cycle.
  task automatic test_directed_cases();
    stall_pattern = 16'b1101_1011_0111_1110;
    gaps_on       = 1'b1;
    send_request(KIND_DETECT, 0, 0);        // empty graph: not found
    send_request(KIND_REQUEST, 31, 15);     // out of range: all dropped
    send_request(KIND_ALLOC, 20, 0);
    send_request(KIND_DEALLOC, 0, 10);
    send_request(KIND_REQUEST, 19, 12);
    send_request(KIND_DETECT, 31, 15);      // pid/lockid ignored on a search
    // two-party deadlock at the field extremes
    send_request(KIND_ALLOC, 0, 0);
    send_request(KIND_ALLOC, 19, 9);
    send_request(KIND_REQUEST, 0, 9);
    send_request(KIND_REQUEST, 19, 0);
    send_request(KIND_DETECT, 0, 0);
    send_request(KIND_DETECT, 19, 9);       // marks start fresh on each search
    send_request(KIND_DEALLOC, 19, 0);      // drops the waiting edge, cycle gone
    send_request(KIND_DETECT, 0, 0);
    // request then allocate of the same pair leaves only the hold edge
    send_request(KIND_REQUEST, 19, 0);
    send_request(KIND_ALLOC, 19, 0);
    send_request(KIND_DETECT, 7, 3);
    send_request(KIND_REQUEST, 0, 0);       // process waits on a lock it holds
    send_request(KIND_DETECT, 0, 0);
    clear_graph();
  endtask

  // Every lock and NL of the processes in one ring: the longest path the graph can report.
  task automatic test_full_ring();
    stall_pattern = 16'hFFFF;               // no stalls on the result side here
    gaps_on       = 1'b0;
    shuffle_picks();
    for (int i = 0; i < NL; i++) send_request(KIND_ALLOC, proc_pick[i], lock_pick[i]);
    for (int i = 0; i < NL; i++)
      send_request(KIND_REQUEST, proc_pick[i], lock_pick[(i + 1) % NL]);
    send_request(KIND_DETECT, 0, 0);
    send_request(KIND_DEALLOC, proc_pick[4], lock_pick[5]);
    send_request(KIND_DETECT, 0, 0);        // broken ring: long path, no cycle
    clear_graph();
  endtask

  // Result side held off while searches keep coming: the command queue fills
  // and full must hold the request side back without losing anything.
  task automatic test_result_backpressure();
    stall_pattern = 16'hFFFF;
    gaps_on       = 1'b0;
    hold_epoch    = hold_epoch + 1;
    @(posedge clk_i);
    send_request(KIND_ALLOC, 3, 2);
    send_request(KIND_ALLOC, 11, 6);
    send_request(KIND_REQUEST, 3, 6);
    send_request(KIND_REQUEST, 11, 2);
    for (int i = 0; i < 6; i++) send_request(KIND_DETECT, $urandom_range(0, 31),
                                             $urandom_range(0, 15));
    send_request(KIND_DEALLOC, 3, 6);
    send_request(KIND_DETECT, 0, 0);
    clear_graph();
  endtask

  // Rings of random size and members, mostly closed, with noise in between;
  // sometimes the graph is left standing so later rounds see richer graphs.
  // Runs until the whole run has sent about ITEM_TARGET requests.
  task automatic test_random_graphs();
    int k;
    int j;
    bit closed;
    while (items_applied + items_ignored < ITEM_TARGET) begin
      stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom | 16'h0101);
      gaps_on       = ($urandom_range(0, 3) != 0);
      k             = ($urandom_range(0, 5) == 0) ? $urandom_range(6, NL) : $urandom_range(2, 5);
      closed        = ($urandom_range(0, 3) != 0);
      shuffle_picks();
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 3) == 0) send_request(KIND_REQUEST, proc_pick[i], lock_pick[i]);
        send_request(KIND_ALLOC, proc_pick[i], lock_pick[i]);
      end
      for (int i = 0; i < k; i++) begin
        if (closed || i != k - 1)
          send_request(KIND_REQUEST, proc_pick[i], lock_pick[(i + 1) % k]);
        if ($urandom_range(0, 5) == 0) begin
          // noise: out of range ids, or a stray in-range edit
          if ($urandom_range(0, 1))
            send_request(kind_e'($urandom_range(0, 2)), $urandom_range(NP, 31),
                         $urandom_range(0, 15));
          else if ($urandom_range(0, 1))
            send_request(kind_e'($urandom_range(0, 2)), $urandom_range(0, 31),
                         $urandom_range(NL, 15));
          else
            send_request(kind_e'($urandom_range(0, 2)), $urandom_range(0, NP - 1),
                         $urandom_range(0, NL - 1));
        end
      end
      send_request(KIND_DETECT, $urandom_range(0, 31), $urandom_range(0, 15));
      j = $urandom_range(0, k - 1);
      send_request(KIND_DEALLOC, proc_pick[j], lock_pick[(j + 1) % k]);
      send_request(KIND_DETECT, $urandom_range(0, 31), $urandom_range(0, 15));
      if ($urandom_range(0, 2) != 0) clear_graph();
    end
  endtask

  initial begin
    for (int v = 0; v < NV; v++) rag_adj[v] = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_full_ring();
    test_result_backpressure();
    test_random_graphs();
    push <= 1'b0;
    while (expected_path_q.size() != 0) @(posedge clk_i);
    // a stray extra result would show up within one more search time
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("covered %0d graph edits and searches (%0d with a cycle, %0d clean), %0d dropped",
             items_applied, searches_found, searches_clean, items_ignored);
    $display("checked %0d results, longest path %0d, request side held by full %0d cycles",
             results_checked, longest_path, full_stall_cycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
